### rtl/core/zdi_pkg.sv
// ----------------------------------------------------------------------------
// zdi_pkg: shared types and constants for the serial debug master
// Command codes, field widths, register indexes and the result record.
// ----------------------------------------------------------------------------
package zdi_pkg;

    localparam int HALF_W  = 10;
    localparam int HOLD_W  = 16;
    localparam int PHASE_W = 16;
    localparam int BYTE_W  = 8;
    localparam int BITCNT_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1);
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(1000);
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_RESET = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 1'd0,
        CFG_RESET_HOLD  = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic              zcl;
        logic              zda_out;
        logic              zda_oe;
        logic              tgt_rst_n;
        logic              busy_res;
        logic              cmd_dropped;
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
    } result_t;

endpackage

### rtl/core/zdi_serial_debug_master_core.sv
// ----------------------------------------------------------------------------
// zdi_serial_debug_master_core: tick-driven two-wire debug bus master
// Every input transfer is one bus tick; every tick yields one pin-level result.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one tick: an optional command
// (cmd_valid, func, cmd_byte, read_not_write, last) and the sampled data pin
// zda_in. The sequencer steps once per accepted transfer and the pin levels
// after that step (zcl, zda_out, zda_oe, tgt_rst_n, busy_res, cmd_dropped,
// read_data, read_valid) appear on the output channel (out_valid/out_stall).
// Results are registered in the result register; one transfer per cycle is
// sustained while the receiver does not stall, set by the single state
// update step feeding the result register. A skid register behind it lets
// one more tick in while the receiver stalls; in_stall rises only once that
// skid entry is occupied, and is itself a register output.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set the phase length
// and target reset hold time; write them only while the block is idle.
// Reset puts the sequencer at idle: clock high, data driven low, target reset
// released, no result pending; the result register itself is not reset.
// ----------------------------------------------------------------------------
module zdi_serial_debug_master_core
    import zdi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd_valid,
    input  logic [1:0]            func,
    input  logic [BYTE_W-1:0]     cmd_byte,
    input  logic                  read_not_write,
    input  logic                  last,
    input  logic                  zda_in,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  zcl,
    output logic                  zda_out,
    output logic                  zda_oe,
    output logic                  tgt_rst_n,
    output logic                  busy_res,
    output logic                  cmd_dropped,
    output logic [BYTE_W-1:0]     read_data,
    output logic                  read_valid
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_START = 3'd1,
        ST_LOW   = 3'd2,
        ST_HIGH  = 3'd3,
        ST_RESET = 3'd4
    } op_state_t;

    logic [HALF_W-1:0]   half_reg;
    logic [HOLD_W-1:0]   hold_reg;

    op_state_t           state_reg, state_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic                sep_reg, sep_next;
    logic                clk_lvl_reg, clk_lvl_next;
    logic                data_lvl_reg, data_lvl_next;
    logic                drive_reg, drive_next;
    logic                tgt_rst_reg, tgt_rst_next;
    logic [BYTE_W-1:0]   held_reg, held_next;

    logic                dropped;
    logic                rvalid;
    logic                go_low;
    logic [PHASE_W-1:0]  phase_len;
    logic [PHASE_W-1:0]  hold_len;
    logic                accept;
    result_t             step_res;

    result_t             out_reg;
    logic                out_valid_reg;
    result_t             skid_reg;
    logic                skid_valid_reg;

    assign accept    = in_valid && !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign phase_len = (half_reg == '0) ? PHASE_W'(1) : PHASE_W'(half_reg);
    assign hold_len  = (hold_reg == '0) ? PHASE_W'(1) : PHASE_W'(hold_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_reg <= cfg_wdata[HALF_W-1:0];
                CFG_RESET_HOLD:  hold_reg <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // one bus tick
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        bitcnt_next   = bitcnt_reg;
        shift_next    = shift_reg;
        sep_next      = sep_reg;
        clk_lvl_next  = clk_lvl_reg;
        data_lvl_next = data_lvl_reg;
        drive_next    = drive_reg;
        tgt_rst_next  = tgt_rst_reg;
        held_next     = held_reg;
        dropped       = 1'b0;
        rvalid        = 1'b0;
        go_low        = 1'b0;

        if (state_reg == ST_IDLE)
        begin
            if (cmd_valid)
            begin
                bitcnt_next  = '0;
                clk_lvl_next = 1'b1;
                case (func_t'(func))
                    FUNC_START:
                    begin
                        shift_next    = {cmd_byte[BYTE_W-2:0], read_not_write};
                        sep_next      = 1'b0;
                        drive_next    = 1'b1;
                        data_lvl_next = 1'b0;
                        state_next    = ST_START;
                        phase_next    = phase_len;
                    end
                    FUNC_WRITE:
                    begin
                        shift_next = cmd_byte;
                        sep_next   = last;
                        drive_next = 1'b1;
                        go_low     = 1'b1;
                    end
                    FUNC_READ:
                    begin
                        shift_next = '0;
                        sep_next   = last;
                        drive_next = 1'b0;
                        go_low     = 1'b1;
                    end
                    default:
                    begin
                        tgt_rst_next  = 1'b0;
                        data_lvl_next = 1'b0;
                        drive_next    = 1'b1;
                        state_next    = ST_RESET;
                        phase_next    = hold_len;
                    end
                endcase
            end
        end
        else
        begin
            dropped = cmd_valid;
            if (phase_reg > PHASE_W'(1))
            begin
                phase_next = phase_reg - PHASE_W'(1);
            end
            else
            begin
                case (state_reg)
                    ST_START:
                    begin
                        bitcnt_next = '0;
                        go_low      = 1'b1;
                    end
                    ST_LOW:
                    begin
                        state_next   = ST_HIGH;
                        phase_next   = phase_len;
                        clk_lvl_next = 1'b1;
                    end
                    ST_HIGH:
                    begin
                        if (bitcnt_reg < BITS_PER_BYTE)
                        begin
                            // sample at the end of the high phase while released
                            if (!drive_reg)
                                shift_next = {shift_reg[BYTE_W-2:0], zda_in};
                            bitcnt_next = bitcnt_reg + BITCNT_W'(1);
                            go_low      = 1'b1;
                        end
                        else
                        begin
                            state_next  = ST_IDLE;
                            phase_next  = '0;
                            bitcnt_next = '0;
                            if (!drive_reg)
                            begin
                                held_next  = shift_reg;
                                rvalid     = 1'b1;
                                drive_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        tgt_rst_next = 1'b1;
                        state_next   = ST_IDLE;
                        phase_next   = '0;
                    end
                endcase
            end
        end

        // enter the low phase of the next bit
        if (go_low)
        begin
            state_next   = ST_LOW;
            phase_next   = phase_len;
            clk_lvl_next = 1'b0;
            if (bitcnt_next >= BITS_PER_BYTE)
            begin
                data_lvl_next = sep_next;
            end
            else if (drive_next)
            begin
                data_lvl_next = shift_next[BYTE_W-1];
                shift_next    = {shift_next[BYTE_W-2:0], 1'b0};
            end
            else
            begin
                data_lvl_next = 1'b1;
            end
        end

        step_res.zcl         = clk_lvl_next;
        step_res.zda_out     = data_lvl_next;
        step_res.zda_oe      = drive_next;
        step_res.tgt_rst_n   = tgt_rst_next;
        step_res.busy_res    = (state_next != ST_IDLE);
        step_res.cmd_dropped = dropped;
        step_res.read_data   = held_next;
        step_res.read_valid  = rvalid;
    end

    // sequencer state, advanced once per input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            bitcnt_reg   <= '0;
            shift_reg    <= '0;
            sep_reg      <= 1'b0;
            clk_lvl_reg  <= 1'b1;
            data_lvl_reg <= 1'b0;
            drive_reg    <= 1'b1;
            tgt_rst_reg  <= 1'b1;
            held_reg     <= '0;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            bitcnt_reg   <= bitcnt_next;
            shift_reg    <= shift_next;
            sep_reg      <= sep_next;
            clk_lvl_reg  <= clk_lvl_next;
            data_lvl_reg <= data_lvl_next;
            drive_reg    <= drive_next;
            tgt_rst_reg  <= tgt_rst_next;
            held_reg     <= held_next;
        end
    end

    // result register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= step_res;
        end
        else if (accept)
        begin
            // hold the stalled result, park the new one
            skid_reg <= step_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign zcl         = out_reg.zcl;
    assign zda_out     = out_reg.zda_out;
    assign zda_oe      = out_reg.zda_oe;
    assign tgt_rst_n   = out_reg.tgt_rst_n;
    assign busy_res    = out_reg.busy_res;
    assign cmd_dropped = out_reg.cmd_dropped;
    assign read_data   = out_reg.read_data;
    assign read_valid  = out_reg.read_valid;

endmodule
